// ===== hdl/enrs_pkg.sv =====
// ----------------------------------------------------------------------------
// enrs_pkg
// Shared types and constants for the edge node rename and scatter block.
// ----------------------------------------------------------------------------
package enrs_pkg;

   // item codes
   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_EDGE = 2'd1;
   localparam logic [1:0] OP_NEXT = 2'd2;

   // configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 7;
   localparam logic [CSR_INDEX_W-1:0] CSR_GROUP_RENUMBER = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_BUCKET   = 1'b1;

   // edge word layout
   localparam int EDGE_W       = 64;
   localparam int EDGE_LO_W    = 32;
   localparam int NODE_LSB     = 39;
   localparam int NODE_SRC_W   = EDGE_W - NODE_LSB;
   localparam int BUCKET_SRC_W = 7;

   // result layout
   localparam int ID_W       = 16;
   localparam int TAG_W      = 2;
   localparam int TAG_LSB    = 48;
   localparam int OUT_PAD_W  = EDGE_W - TAG_LSB - TAG_W;
   localparam int SLOT_W     = 13;
   localparam int BUCKET_NUM_W = 7;
   localparam int GROUP_BITS   = 5;
   localparam int STATUS_W     = 2;

   typedef struct packed {
      logic [1:0]              op;
      logic [14:0]             node_index;
      logic [STATUS_W-1:0]     status_value;
      logic [EDGE_W-1:0]       edge_word;
   } req_payload_type;

   typedef struct packed {
      logic [BUCKET_NUM_W-1:0] dest_bucket;
      logic [SLOT_W-1:0]       slot;
      logic [EDGE_W-1:0]       out_word;
      logic                    keep;
      logic                    overflow;
   } rsp_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     id;
   } node_word_type;

endpackage

// ===== hdl/edge_node_rename_scatter.sv =====
// ----------------------------------------------------------------------------
// edge_node_rename_scatter
// Node renaming and edge scatter for one trimming round. Takes one item per
// clock cycle while req_stall is low: load items fill the node status
// table, edge items rename their node and come out with a destination
// bucket and slot, next-bucket items step the source bucket and may restart
// node ids. An edge result is registered through each pipeline stage.
// The node table (status and id) and the bucket fill table each sit in a
// simple dual-port synchronous RAM, one read and one write port, that is
// read one stage ahead and written back in the following stage; a
// forwarding path covers back-to-back items that touch the same entry, so
// the rate is set by the one read-modify-write per item.
// Node and bucket numbers are reduced modulo the table sizes by a
// reciprocal multiply spread over the first two stages. After reset a
// clearing pass zeroes both tables, one node entry per cycle; req_stall
// stays high during that pass while configuration writes are still taken.
// ----------------------------------------------------------------------------
module edge_node_rename_scatter #(
   parameter int NODE_ENTRIES = 32768,
   parameter int BUCKET_SLOTS = 8192,
   parameter int DEST_BUCKETS = 128
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  enrs_pkg::req_payload_type            req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output enrs_pkg::rsp_payload_type            rsp_payload,
   input  logic                                 csr_wr_en,
   input  logic [enrs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [enrs_pkg::CSR_DATA_W-1:0]      csr_data
);
   import enrs_pkg::*;

   localparam int NW  = $clog2(NODE_ENTRIES);
   localparam int NIW = NW + 1;
   localparam int BW  = $clog2(DEST_BUCKETS);
   localparam int BIW = BW + 1;
   localparam int FW  = $clog2(BUCKET_SLOTS + 1);

   // node modulo: q = (x * RECIP_N) >> SHN, then one correction
   localparam int NRW = 27;
   localparam int NPW = NODE_SRC_W + NRW;
   localparam int SHN = NODE_SRC_W + NW;
   localparam int NQW = NPW - SHN;
   localparam int NXW = NODE_SRC_W + 1;
   localparam logic [NRW-1:0] RECIP_N = NRW'((64'd1 << SHN) / 64'(NODE_ENTRIES));
   localparam logic [NIW-1:0] NODE_LIMIT = NIW'(NODE_ENTRIES);

   // bucket modulo, same scheme on the 7-bit bucket field
   localparam int BRW = 9;
   localparam int BPW = BUCKET_SRC_W + BRW;
   localparam int SHB = BUCKET_SRC_W + BW;
   localparam int BQW = BPW - SHB;
   localparam int BXW = BUCKET_SRC_W + 3;
   localparam logic [BRW-1:0] RECIP_B = BRW'((32'd1 << SHB) / 32'(DEST_BUCKETS));
   localparam logic [BIW-1:0] BUCKET_LIMIT = BIW'(DEST_BUCKETS);

   localparam logic [FW-1:0]     FILL_LIMIT = FW'(BUCKET_SLOTS);
   localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(BUCKET_SLOTS - 1);
   localparam logic [NW-1:0]     CLEAR_LAST = NW'(NODE_ENTRIES - 1);

   // storage
   node_word_type     node_ram   [NODE_ENTRIES];
   logic [FW-1:0]     bucket_ram [DEST_BUCKETS];

   // control and configuration
   logic                     clear_ff;
   logic [NW-1:0]            clear_addr_ff;
   logic                     group_renumber_ff;
   logic [BUCKET_NUM_W-1:0]  bucket_number_ff;
   logic [BUCKET_NUM_W-1:0]  bucket_number_in;
   logic [ID_W-1:0]          next_id_ff;
   logic [ID_W-1:0]          next_id_in;
   logic [TAG_W-1:0]         group_tag_ff;
   logic [TAG_W-1:0]         group_tag_in;

   // stage 1
   logic                     s1_v_ff;
   logic [1:0]               s1_op_ff;
   logic [STATUS_W-1:0]      s1_sv_ff;
   logic [EDGE_LO_W-1:0]     s1_lo_ff;
   logic [NODE_SRC_W-1:0]    s1_xn_ff;
   logic [BUCKET_SRC_W-1:0]  s1_xb_ff;
   logic [NPW-1:0]           s1_pn_ff;
   logic [BPW-1:0]           s1_pb_ff;
   logic [NODE_SRC_W-1:0]    xn_in;

   // stage 2
   logic                     s2_v_ff;
   logic [1:0]               s2_op_ff;
   logic [STATUS_W-1:0]      s2_sv_ff;
   logic [EDGE_LO_W-1:0]     s2_lo_ff;
   logic [NIW-1:0]           s2_rn_ff;
   logic [BIW-1:0]           s2_rb_ff;
   logic [NQW-1:0]           n_q;
   logic [BQW-1:0]           b_q;
   logic [NXW-1:0]           n_rem;
   logic [BXW-1:0]           b_rem;
   logic [NIW-1:0]           rn_fix;
   logic [BIW-1:0]           rb_fix;
   logic [NW-1:0]            rd_node_idx;
   logic [BW-1:0]            rd_bucket_idx;

   // stage 3
   logic                     s3_v_ff;
   logic [1:0]               s3_op_ff;
   logic [STATUS_W-1:0]      s3_sv_ff;
   logic [EDGE_LO_W-1:0]     s3_lo_ff;
   logic [NW-1:0]            s3_node_idx_ff;
   logic [BW-1:0]            s3_bucket_idx_ff;
   node_word_type            node_q_ff;
   logic [FW-1:0]            bucket_q_ff;
   logic                     node_fwd_hit_ff;
   node_word_type            node_fwd_data_ff;
   logic                     bucket_fwd_hit_ff;
   logic [FW-1:0]            bucket_fwd_data_ff;

   node_word_type            node_cur;
   logic [FW-1:0]            fill_cur;
   logic                     s3_edge;
   logic                     s3_fire;
   logic [STATUS_W-1:0]      st_plus;
   logic [ID_W-1:0]          id_out;
   logic                     full;
   logic                     keep;
   logic                     ovf;
   logic                     s3_node_we;
   node_word_type            s3_node_wd;
   logic                     s3_bucket_we;
   logic [FW-1:0]            s3_bucket_wd;

   // memory ports
   logic                     node_we;
   logic [NW-1:0]            node_wa;
   node_word_type            node_wd;
   logic                     bucket_we;
   logic [BW-1:0]            bucket_wa;
   logic [FW-1:0]            bucket_wd;

   // output register
   logic                     rsp_valid_ff;
   rsp_payload_type          rsp_payload_ff;
   rsp_payload_type          rsp_payload_in;

   logic                     en1;
   logic                     en2;
   logic                     en3;
   logic                     accept;

   // pipeline flow: a stage loads when it is empty or its item moves on
   assign s3_edge = s3_v_ff && (s3_op_ff == OP_EDGE);
   assign s3_fire = s3_v_ff && ((s3_op_ff != OP_EDGE) || !rsp_valid_ff || !rsp_stall);
   assign en3     = !s3_v_ff || s3_fire;
   assign en2     = !s2_v_ff || en3;
   assign en1     = !s1_v_ff || en2;
   assign req_stall = clear_ff || !en1;
   assign accept    = req_valid && !req_stall;

   // stage 1: start of the modulo reductions
   always_comb begin
      if (req_payload.op == OP_LOAD) begin
         xn_in = NODE_SRC_W'(req_payload.node_index);
      end else begin
         xn_in = req_payload.edge_word[NODE_LSB +: NODE_SRC_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en1) begin
         s1_v_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_op_ff <= req_payload.op;
         s1_sv_ff <= req_payload.status_value;
         s1_lo_ff <= req_payload.edge_word[EDGE_LO_W-1:0];
         s1_xn_ff <= xn_in;
         s1_xb_ff <= req_payload.edge_word[BUCKET_SRC_W-1:0];
         s1_pn_ff <= NPW'(xn_in) * NPW'(RECIP_N);
         s1_pb_ff <= BPW'(req_payload.edge_word[BUCKET_SRC_W-1:0]) * BPW'(RECIP_B);
      end
   end

   // stage 2: remainder before its final correction
   assign n_q   = s1_pn_ff[NPW-1:SHN];
   assign b_q   = s1_pb_ff[BPW-1:SHB];
   assign n_rem = NXW'(s1_xn_ff) - NXW'(n_q) * NXW'(NODE_ENTRIES);
   assign b_rem = BXW'(s1_xb_ff) - BXW'(b_q) * BXW'(DEST_BUCKETS);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en2) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_op_ff <= s1_op_ff;
         s2_sv_ff <= s1_sv_ff;
         s2_lo_ff <= s1_lo_ff;
         s2_rn_ff <= n_rem[NW:0];
         s2_rb_ff <= b_rem[BW:0];
      end
   end

   always_comb begin
      rn_fix = (s2_rn_ff >= NODE_LIMIT) ? (s2_rn_ff - NODE_LIMIT) : s2_rn_ff;
      rb_fix = (s2_rb_ff >= BUCKET_LIMIT) ? (s2_rb_ff - BUCKET_LIMIT) : s2_rb_ff;
   end

   assign rd_node_idx   = rn_fix[NW-1:0];
   assign rd_bucket_idx = rb_fix[BW-1:0];

   // stage 3: read-modify-write
   assign node_cur = node_fwd_hit_ff ? node_fwd_data_ff : node_q_ff;
   assign fill_cur = bucket_fwd_hit_ff ? bucket_fwd_data_ff : bucket_q_ff;

   always_comb begin
      st_plus = node_cur.status + STATUS_W'(1);
      id_out  = node_cur.status[0] ? next_id_ff : node_cur.id;
      full    = fill_cur >= FILL_LIMIT;
      keep    = st_plus[1] && !full;
      ovf     = st_plus[1] && full;

      s3_node_we = s3_fire && ((s3_op_ff == OP_LOAD) || (s3_op_ff == OP_EDGE));
      if (s3_op_ff == OP_LOAD) begin
         s3_node_wd.status = s3_sv_ff;
         s3_node_wd.id     = node_cur.id;
      end else begin
         s3_node_wd.status = {st_plus[1], 1'b0};
         s3_node_wd.id     = id_out;
      end

      s3_bucket_we = s3_fire && s3_edge && keep;
      s3_bucket_wd = fill_cur + FW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (en3) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_op_ff           <= s2_op_ff;
         s3_sv_ff           <= s2_sv_ff;
         s3_lo_ff           <= s2_lo_ff;
         s3_node_idx_ff     <= rd_node_idx;
         s3_bucket_idx_ff   <= rd_bucket_idx;
         // the write that lands on the same edge as this read is forwarded
         node_fwd_hit_ff    <= s3_node_we && (s3_node_idx_ff == rd_node_idx);
         node_fwd_data_ff   <= s3_node_wd;
         bucket_fwd_hit_ff  <= s3_bucket_we && (s3_bucket_idx_ff == rd_bucket_idx);
         bucket_fwd_data_ff <= s3_bucket_wd;
      end
   end

   // memory ports, shared with the clearing pass
   always_comb begin
      if (clear_ff) begin
         node_we   = 1'b1;
         node_wa   = clear_addr_ff;
         node_wd   = '0;
         bucket_we = {1'b0, clear_addr_ff} < NIW'(DEST_BUCKETS);
         bucket_wa = clear_addr_ff[BW-1:0];
         bucket_wd = '0;
      end else begin
         node_we   = s3_node_we;
         node_wa   = s3_node_idx_ff;
         node_wd   = s3_node_wd;
         bucket_we = s3_bucket_we;
         bucket_wa = s3_bucket_idx_ff;
         bucket_wd = s3_bucket_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_ram[node_wa] <= node_wd;
      end
      if (en3) begin
         node_q_ff <= node_ram[rd_node_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (bucket_we) begin
         bucket_ram[bucket_wa] <= bucket_wd;
      end
      if (en3) begin
         bucket_q_ff <= bucket_ram[rd_bucket_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_ff) begin
         clear_addr_ff <= clear_addr_ff + NW'(1);
         if (clear_addr_ff == CLEAR_LAST) begin
            clear_ff <= 1'b0;
         end
      end
   end

   // id counter, group tag and source bucket
   always_comb begin
      next_id_in       = next_id_ff;
      group_tag_in     = group_tag_ff;
      bucket_number_in = bucket_number_ff;
      if (s3_fire && s3_edge && node_cur.status[0]) begin
         next_id_in = next_id_ff + ID_W'(1);
      end
      if (s3_fire && (s3_op_ff == OP_NEXT)) begin
         bucket_number_in = bucket_number_ff + BUCKET_NUM_W'(1);
         if (group_renumber_ff && (bucket_number_in[GROUP_BITS-1:0] == '0)) begin
            next_id_in   = ID_W'(1);
            group_tag_in = group_tag_ff + TAG_W'(1);
         end
      end
      if (csr_wr_en && (csr_index == CSR_FIRST_BUCKET)) begin
         bucket_number_in = csr_data[BUCKET_NUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_renumber_ff <= 1'b1;
         bucket_number_ff  <= '0;
         next_id_ff        <= ID_W'(1);
         group_tag_ff      <= '0;
      end else begin
         if (csr_wr_en && (csr_index == CSR_GROUP_RENUMBER)) begin
            group_renumber_ff <= csr_data[0];
         end
         bucket_number_ff <= bucket_number_in;
         next_id_ff       <= next_id_in;
         group_tag_ff     <= group_tag_in;
      end
   end

   // result register
   always_comb begin
      rsp_payload_in.dest_bucket = BUCKET_NUM_W'(s3_bucket_idx_ff);
      rsp_payload_in.slot        = full ? SLOT_LAST : SLOT_W'(fill_cur);
      rsp_payload_in.out_word    = {{OUT_PAD_W{1'b0}}, group_tag_ff, id_out, s3_lo_ff};
      rsp_payload_in.keep        = keep;
      rsp_payload_in.overflow    = ovf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s3_fire && s3_edge) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_fire && s3_edge) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // pipeline stays empty while the tables are being cleared
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> (!s1_v_ff && !s2_v_ff && !s3_v_ff))
      else $error("item in flight during table clear");

   // a finished edge always lands in the result register
   a_edge_result: assert property (@(posedge clock) disable iff (reset)
      (s3_fire && s3_edge) |=> rsp_valid_ff)
      else $error("edge result lost");

   // the fill pointer saturates at the bucket capacity
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      s3_edge |-> (fill_cur <= FILL_LIMIT))
      else $error("bucket fill beyond capacity");

   // an edge is either kept, overflowed or dropped, never kept and overflowed
   a_keep_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_payload_ff.keep && rsp_payload_ff.overflow))
      else $error("keep and overflow both set");

endmodule

// ===== verif/tb_edge_node_rename_scatter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_edge_node_rename_scatter
// Self-checking bench for the node rename and edge scatter block. A short
// table of directed items covers the field extremes, every status and the
// dropped, unused-op and reuse paths. Random phases under several register
// settings then follow. A back-to-back phase walks the group tag through
// its wrap. Every edge result is checked field by field against a behavioral
// copy of the block state that is kept in step with each input transfer.
// ----------------------------------------------------------------------------
module tb_edge_node_rename_scatter;
   import enrs_pkg::*;

   localparam int NODE_ENTRIES = 32768;
   localparam int BUCKET_SLOTS = 8192;
   localparam int DEST_BUCKETS = 128;
   localparam int NODE_IDX_W   = 15;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int PIPE_DRAIN   = 8;
   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int PHASE_ITEMS  = 210;
   localparam int HOLD_AFTER   = 120;
   localparam int HOLD_CYCLES  = 300;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_payload_type        req_payload;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_payload_type        rsp_payload;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // shadow of the block state
   logic [STATUS_W-1:0]     node_state [NODE_ENTRIES];
   logic [ID_W-1:0]         node_id [NODE_ENTRIES];
   int unsigned             bucket_fill [DEST_BUCKETS];
   logic [ID_W-1:0]         next_id;
   logic [TAG_W-1:0]        group_tag;
   logic [BUCKET_NUM_W-1:0] src_bucket;
   logic                    renumber_on;

   rsp_payload_type expected_scatter [$];
   int unsigned     results_seen;
   int unsigned     mismatches;
   int unsigned     cycle_count;
   bit              steady;
   bit              hold_done;
   int unsigned     node_pool [16];

   typedef struct {
      req_payload_type item;
      bit              typed;
      rsp_payload_type result;
   } stim_row_type;

   stim_row_type directed_rows [$];

   edge_node_rename_scatter #(
      .NODE_ENTRIES(NODE_ENTRIES),
      .BUCKET_SLOTS(BUCKET_SLOTS),
      .DEST_BUCKETS(DEST_BUCKETS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic req_payload_type make_item(input logic [1:0] op, input int unsigned node,
                                                 input logic [1:0] status,
                                                 input logic [EDGE_W-1:0] word);
      req_payload_type p;
      p.op           = op;
      p.node_index   = NODE_IDX_W'(node);
      p.status_value = status;
      p.edge_word    = word;
      return p;
   endfunction

   // renames the node of one transfer and works out where its edge lands
   function automatic bit rename_step(input req_payload_type p, output rsp_payload_type r);
      int unsigned         idx;
      int unsigned         b;
      int unsigned         fill;
      logic [STATUS_W-1:0] st;
      logic [STATUS_W-1:0] nst;
      logic [ID_W-1:0]     id;
      r = '0;
      if (p.op == OP_LOAD) begin
         node_state[p.node_index % NODE_ENTRIES] = p.status_value;
         return 1'b0;
      end
      if (p.op == OP_NEXT) begin
         src_bucket = src_bucket + 1'b1;
         if (renumber_on && src_bucket[GROUP_BITS-1:0] == '0) begin
            next_id   = ID_W'(1);
            group_tag = group_tag + 1'b1;
         end
         return 1'b0;
      end
      if (p.op != OP_EDGE) return 1'b0;
      idx = 32'((p.edge_word >> NODE_LSB) % NODE_ENTRIES);
      st  = node_state[idx];
      id  = node_id[idx];
      // odd status takes a fresh id; status three then falls to drop
      if (st[0]) begin
         id          = next_id;
         node_id[idx] = id;
         next_id     = next_id + 1'b1;
      end
      nst = (st + 1'b1) & 2'b10;
      node_state[idx] = nst;
      b    = p.edge_word[BUCKET_SRC_W-1:0] % DEST_BUCKETS;
      fill = bucket_fill[b];
      r.dest_bucket = b[BUCKET_NUM_W-1:0];
      if (fill >= BUCKET_SLOTS) begin
         r.slot     = SLOT_W'(BUCKET_SLOTS - 1);
         r.overflow = (nst != '0);
      end else begin
         r.slot = SLOT_W'(fill);
         if (nst != '0) begin
            r.keep         = 1'b1;
            bucket_fill[b] = fill + 1;
         end
      end
      r.out_word = {{OUT_PAD_W{1'b0}}, group_tag, id, p.edge_word[EDGE_LO_W-1:0]};
      return 1'b1;
   endfunction

   function automatic req_payload_type random_item();
      req_payload_type p;
      int roll;
      p = make_item(OP_LOAD, $urandom, 2'($urandom), {$urandom, $urandom});
      roll = $urandom_range(0, 99);
      if (roll < 18) begin
         p.op = OP_LOAD;
         if ($urandom_range(0, 9) != 0)
            p.node_index = NODE_IDX_W'(node_pool[$urandom_range(0, 15)]);
      end else if (roll < 87) begin
         p.op = OP_EDGE;
         if ($urandom_range(0, 6) != 0)
            p.edge_word[NODE_LSB +: NODE_IDX_W] = NODE_IDX_W'(node_pool[$urandom_range(0, 15)]);
      end else if (roll < 97) begin
         p.op = OP_NEXT;
      end else begin
         p.op = OP_UNUSED;
      end
      return p;
   endfunction

   task automatic send_item(input req_payload_type p, input bit typed,
                            input rsp_payload_type want);
      int              gap;
      rsp_payload_type got;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      do begin
         @(posedge clock);
      end while (req_stall);
      if (rename_step(p, got)) expected_scatter.push_back(typed ? want : got);
   endtask

   task automatic wait_results(input bit settle);
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (expected_scatter.size() != 0);
      // loads and bucket steps give no result but may still be in flight
      if (settle) repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   task automatic apply_settings(input logic renumber, input logic [BUCKET_NUM_W-1:0] first);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_GROUP_RENUMBER;
      csr_data  <= CSR_DATA_W'(renumber);
      @(posedge clock);
      csr_index <= CSR_FIRST_BUCKET;
      csr_data  <= first;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      renumber_on = renumber;
      src_bucket  = first;
   endtask

   task automatic add_row(input req_payload_type p);
      stim_row_type row;
      row.item   = p;
      row.typed  = 1'b0;
      row.result = '0;
      directed_rows.push_back(row);
   endtask

   task automatic add_checked(input logic [EDGE_W-1:0] word, input int unsigned dest,
                              input int unsigned slot, input logic [EDGE_W-1:0] out,
                              input logic keep);
      stim_row_type row;
      row.item               = make_item(OP_EDGE, 0, 2'd0, word);
      row.typed              = 1'b1;
      row.result.dest_bucket = BUCKET_NUM_W'(dest);
      row.result.slot        = SLOT_W'(slot);
      row.result.out_word    = out;
      row.result.keep        = keep;
      row.result.overflow    = 1'b0;
      directed_rows.push_back(row);
   endtask

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : scatter_check
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_scatter.size() == 0) begin
            $display("%0t: result with no transfer pending, got %h", $time, rsp_payload);
            mismatches++;
         end else begin
            want = expected_scatter.pop_front();
            check_field("dest_bucket", 64'(want.dest_bucket), 64'(rsp_payload.dest_bucket));
            check_field("slot", 64'(want.slot), 64'(rsp_payload.slot));
            check_field("out_word", want.out_word, rsp_payload.out_word);
            check_field("keep", 64'(want.keep), 64'(rsp_payload.keep));
            check_field("overflow", 64'(want.overflow), 64'(rsp_payload.overflow));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_edge_node_rename_scatter: done, errors");
         $finish;
      end
   end

   // result side: random stalls plus one long hold-off to back up the pipe
   initial begin : rsp_side
      int len;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         len = pick_gap();
         if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            len       = HOLD_CYCLES;
         end
         if (len > 0) begin
            rsp_stall <= 1'b1;
            repeat (len) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   initial begin : stimulus
      int unsigned count;
      bit                      phase_renumber [4];
      logic [BUCKET_NUM_W-1:0] phase_first [4];

      phase_renumber = '{1'b1, 1'b0, 1'b1, 1'b1};
      phase_first    = '{7'd0, 7'd127, 7'd127, 7'd31};
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_wr_en   <= 1'b0;
      csr_index   <= '0;
      csr_data    <= '0;
      for (int i = 0; i < NODE_ENTRIES; i++) begin
         node_state[i] = '0;
         node_id[i]    = '0;
      end
      for (int i = 0; i < DEST_BUCKETS; i++) bucket_fill[i] = 0;
      next_id     = ID_W'(1);
      group_tag   = '0;
      src_bucket  = '0;
      renumber_on = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed rows, from the reset state
      add_checked(64'h0, 0, 0, 64'h0, 1'b0);
      add_checked('1, 127, 0, 64'h0000_0000_ffff_ffff, 1'b0);
      add_row(make_item(OP_LOAD, 32767, 2'd1, '0));
      add_checked('1, 127, 0, 64'h0000_0001_ffff_ffff, 1'b1);
      add_checked('1, 127, 1, 64'h0000_0001_ffff_ffff, 1'b1);
      add_row(make_item(OP_LOAD, 5, 2'd3, '1));
      add_row(make_item(OP_EDGE, 0, 2'd0, (64'd5 << NODE_LSB) | 64'h1234_5640));
      add_row(make_item(OP_EDGE, 0, 2'd0, (64'd5 << NODE_LSB) | 64'h1234_5640));
      add_row(make_item(OP_UNUSED, 32767, 2'd3, '1));
      add_row(make_item(OP_LOAD, 0, 2'd2, '0));
      add_row(make_item(OP_EDGE, 0, 2'd0, 64'h0000_0000_9abc_de01));
      add_row(make_item(OP_NEXT, 0, 2'd0, '0));
      add_row(make_item(OP_NEXT, 32767, 2'd3, '1));
      add_row(make_item(OP_LOAD, 32767, 2'd0, '0));
      add_row(make_item(OP_EDGE, 0, 2'd0, '1));
      add_row(make_item(OP_EDGE, 0, 2'd0, 64'h8000_0000_0000_0000));
      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
      wait_results(1'b1);

      for (int ph = 0; ph < 4; ph++) begin
         apply_settings(phase_renumber[ph], phase_first[ph]);
         foreach (node_pool[i]) node_pool[i] = $urandom_range(0, NODE_ENTRIES - 1);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k == PHASE_ITEMS / 4) wait_results(1'b0);
            send_item(random_item(), 1'b0, '0);
         end
         wait_results(1'b1);
      end

      // four group crossings walk the tag around, back to back
      steady = 1'b1;
      apply_settings(1'b1, 7'd0);
      for (count = 0; count < 130; count++) begin
         send_item(make_item(OP_NEXT, $urandom, 2'($urandom), {$urandom, $urandom}), 1'b0, '0);
         if (count % 16 == 0)
            send_item(make_item(OP_EDGE, $urandom, 2'($urandom), {$urandom, $urandom}),
                      1'b0, '0);
      end
      steady = 1'b0;
      wait_results(1'b1);

      if (mismatches == 0) begin
         $display("tb_edge_node_rename_scatter: done, clean");
      end else begin
         $display("tb_edge_node_rename_scatter: done, errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/enrs_pkg.sv
hdl/edge_node_rename_scatter.sv
verif/tb_edge_node_rename_scatter.sv
